/* sv/kcc_pkg.sv */
// kcc_pkg: types, codes and fixed widths of the k-means color clusterer.
// No dependencies; used by kcc_isqrt, kcc_div and kmeans_color_clusterer.
`default_nettype none

package kcc_pkg;

  localparam int CLUSTERS = 3;
  localparam int K_W      = 2;   // cluster index width
  localparam int CHANS    = 3;
  localparam int DIST_W   = 34;  // squared distance, 3 * 16-bit squares
  localparam int ROOT_W   = 17;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [31:0] SPREAD_NONE = 32'hFFFF_FFFF;
  localparam logic [31:0] SPREAD_MAX  = 32'hFFFF_FFFE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_ZERO = 3'd0,
    REG_SEED_ONE  = 3'd1,
    REG_SEED_TWO  = 3'd2,
    REG_STOP_THR  = 3'd3,
    REG_ITER_CAP  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEED,
    ST_SWEEP,
    ST_RD,
    ST_MUL,
    ST_SQ_GO,
    ST_SQRT,
    ST_ACC,
    ST_CHECK,
    ST_UPD,
    ST_UPD_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] chan_l;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic       last_point;
  } point_t;

  typedef struct packed {
    logic [1:0]  cluster_index;
    logic [15:0] mean_l;
    logic [15:0] mean_a;
    logic [15:0] mean_b;
    logic [12:0] member_count;
    logic        hit_cap;
    logic        overflow;
    logic        last_cluster;
  } result_t;

  // start control of the iterative helper units; done is a separate output
  typedef struct packed {
    logic start;
  } unit_ctl_t;

endpackage

`default_nettype wire

/* sv/kcc_isqrt.sv */
// kcc_isqrt: bit-serial floor square root, two radicand bits per cycle.
// Depends on kcc_pkg for widths and the control struct.
`default_nettype none

module kcc_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire kcc_pkg::unit_ctl_t         ctl,
  input  wire logic [kcc_pkg::DIST_W-1:0] radicand,
  output logic                            done,
  output logic [kcc_pkg::ROOT_W-1:0]      root
);

  localparam int REM_W = kcc_pkg::ROOT_W + 3;
  localparam int CNT_W = $clog2(kcc_pkg::ROOT_W + 1);

  logic [kcc_pkg::DIST_W-1:0] rad;
  logic [REM_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [REM_W-1:0]           rem_sh;
  logic [REM_W-1:0]           trial;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[kcc_pkg::DIST_W-1 -: 2]};
    trial  = REM_W'({root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[kcc_pkg::DIST_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[kcc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[kcc_pkg::ROOT_W-2:0], 1'b0};
        end
        if (cnt == CNT_W'(kcc_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/kcc_div.sv */
// kcc_div: restoring divider, one quotient bit per cycle.
// Depends on kcc_pkg for the control struct.
`default_nettype none

module kcc_div #(
  parameter int NW = 29,
  parameter int DW = 13
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kcc_pkg::unit_ctl_t ctl,
  input  wire logic [NW-1:0]      num,
  input  wire logic [DW-1:0]      den,
  output logic                    done,
  output logic [NW-1:0]           quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      rem_sh;

  assign rem_sh = {rem, quo[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= num;
        dsr  <= den;
        rem  <= '0;
      end else if (busy) begin
        // quotient bits shift in as numerator bits shift out
        if (rem_sh >= {1'b0, dsr}) begin
          rem <= DW'(rem_sh - {1'b0, dsr});
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DW-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/kmeans_color_clusterer.sv */
// kmeans_color_clusterer: top level, three-way Lloyd k-means over 8-bit Lab points.
// Depends on kcc_pkg, kcc_isqrt and kcc_div.
//
// Points come in on the point channel (valid/stall) at one per cycle while
// point_stall is low and go into an on-chip store of MAX_POINTS entries;
// extras are dropped and flagged. The point with last_point set starts
// clustering, and point_stall stays high until all results are taken. Each
// pass sweeps the store with one shared 16x16 multiplier for nine channel
// squares a point, then a bit-serial root and an accumulate, with a sweep
// setup before and a convergence check after; the mean update between passes
// runs a serial divide per cluster channel, skipping the channels of an empty
// cluster. Three results, one per cluster in index order, then leave on the
// result channel; a stall on it holds the current result unchanged. After the
// third result is taken the block returns to loading with an empty store.
// Reset (rst, synchronous) restores register defaults and an empty store; no
// clearing pass is needed. Configuration writes are taken at any cycle.
`default_nettype none

module kmeans_color_clusterer #(
  parameter int MAX_POINTS = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          point_valid,
  output logic                               point_stall,
  input  wire kcc_pkg::point_t               point,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output kcc_pkg::result_t                   result,
  input  wire logic                          cfg_write,
  input  wire logic [kcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kcc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int SW = CW + 8;
  localparam int NW = SW + 8;
  localparam int KN = kcc_pkg::CLUSTERS;
  localparam int KW = kcc_pkg::K_W;

  kcc_pkg::state_t state, state_next;

  // configuration
  logic [kcc_pkg::CFG_W-1:0] seeds [KN];
  logic [15:0]               stop_thr;
  logic [7:0]                iter_cap;

  // stores
  logic [23:0]   point_mem [MAX_POINTS];
  logic [KW-1:0] label_mem [MAX_POINTS];
  logic [23:0]   pt_q;
  logic [KW-1:0] lab_q;

  logic [CW-1:0] point_count;
  logic [CW-1:0] idx;
  logic          dropped;
  logic          hit;
  logic          first_pass;

  logic [15:0]               means [KN][kcc_pkg::CHANS];
  logic [SW-1:0]             sums  [KN][kcc_pkg::CHANS];
  logic [CW-1:0]             sizes [KN];
  logic [kcc_pkg::DIST_W-1:0] dsq  [KN];
  logic [31:0]               prev_spread;
  logic [31:0]               cur_spread;
  logic [31:0]               spread;
  logic [7:0]                pass_count;

  logic [KW-1:0] k_cnt, pk;
  logic [1:0]    c_cnt, pc;
  logic [3:0]    step;
  logic [31:0]   prod;

  logic [7:0]    ch;
  logic [15:0]   diff;
  logic [KW-1:0] best;
  logic [KW-1:0] old_lab;
  logic [32:0]   spread_sum;
  logic [31:0]   spread_sat;
  logic [31:0]   spread_delta;
  logic          go;
  logic          last_idx;
  logic          upd_last;
  logic          accept_pt;
  logic          accept_res;

  kcc_pkg::unit_ctl_t         sq_ctl, dv_ctl;
  logic                       sq_done, dv_done;
  logic [kcc_pkg::ROOT_W-1:0] root;
  logic [NW-1:0]              quo;
  logic [kcc_pkg::DIST_W-1:0] sq_arg;
  logic [NW-1:0]              dv_num;

  kcc_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sq_ctl),
    .radicand (sq_arg),
    .done     (sq_done),
    .root     (root)
  );

  kcc_div #(.NW(NW), .DW(CW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (dv_ctl),
    .num  (dv_num),
    .den  (sizes[k_cnt]),
    .done (dv_done),
    .quo  (quo)
  );

  // datapath combinational terms
  always_comb begin
    unique case (c_cnt)
      2'd0:    ch = pt_q[23:16];
      2'd1:    ch = pt_q[15:8];
      default: ch = pt_q[7:0];
    endcase
    if ({ch, 8'h00} > means[k_cnt][c_cnt]) diff = {ch, 8'h00} - means[k_cnt][c_cnt];
    else                                   diff = means[k_cnt][c_cnt] - {ch, 8'h00};

    // strict compare keeps ties at the lowest index
    best = '0;
    for (int k = 1; k < KN; k++) begin
      if (dsq[k] < dsq[best]) best = KW'(k);
    end
    old_lab = (lab_q >= KW'(KN)) ? '0 : lab_q;
    sq_arg  = first_pass ? dsq[best] : dsq[old_lab];

    spread_sum = {1'b0, spread} + 33'(root);
    spread_sat = (spread_sum > {1'b0, kcc_pkg::SPREAD_MAX}) ? kcc_pkg::SPREAD_MAX
                                                           : spread_sum[31:0];
    spread_delta = (cur_spread > prev_spread) ? cur_spread - prev_spread
                                              : prev_spread - cur_spread;
    go = (prev_spread == kcc_pkg::SPREAD_NONE) || (spread_delta >= {8'h00, stop_thr, 8'h00});

    last_idx = (idx == point_count - 1'b1);
    upd_last = (c_cnt == 2'd2) && (k_cnt == KW'(KN - 1));
    dv_num   = {sums[k_cnt][c_cnt], 8'h00} + NW'(sizes[k_cnt] >> 1);

    accept_pt  = point_valid && !point_stall;
    accept_res = result_valid && !result_stall;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kcc_pkg::ST_LOAD:     if (accept_pt && point.last_point) state_next = kcc_pkg::ST_SEED;
      kcc_pkg::ST_SEED:     state_next = kcc_pkg::ST_SWEEP;
      kcc_pkg::ST_SWEEP:    state_next = kcc_pkg::ST_RD;
      kcc_pkg::ST_RD:       state_next = kcc_pkg::ST_MUL;
      kcc_pkg::ST_MUL:      if (step == 4'd9) state_next = kcc_pkg::ST_SQ_GO;
      kcc_pkg::ST_SQ_GO:    state_next = kcc_pkg::ST_SQRT;
      kcc_pkg::ST_SQRT:     if (sq_done) state_next = kcc_pkg::ST_ACC;
      kcc_pkg::ST_ACC:      state_next = last_idx ? kcc_pkg::ST_CHECK : kcc_pkg::ST_RD;
      kcc_pkg::ST_CHECK: begin
        state_next = (go && pass_count < iter_cap) ? kcc_pkg::ST_UPD : kcc_pkg::ST_EMIT;
      end
      kcc_pkg::ST_UPD: begin
        if (sizes[k_cnt] != '0) state_next = kcc_pkg::ST_UPD_WAIT;
        else if (upd_last)      state_next = kcc_pkg::ST_SWEEP;
      end
      kcc_pkg::ST_UPD_WAIT: begin
        if (dv_done) state_next = upd_last ? kcc_pkg::ST_SWEEP : kcc_pkg::ST_UPD;
      end
      kcc_pkg::ST_EMIT: begin
        if (accept_res && k_cnt == KW'(KN - 1)) state_next = kcc_pkg::ST_LOAD;
      end
      default:     state_next = kcc_pkg::ST_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    point_stall  = (state != kcc_pkg::ST_LOAD);
    result_valid = (state == kcc_pkg::ST_EMIT);
    sq_ctl.start = (state == kcc_pkg::ST_SQ_GO);
    dv_ctl.start = (state == kcc_pkg::ST_UPD) && (sizes[k_cnt] != '0);
  end

  always_comb begin
    result.cluster_index = 2'(k_cnt);
    result.mean_l        = means[k_cnt][0];
    result.mean_a        = means[k_cnt][1];
    result.mean_b        = means[k_cnt][2];
    result.member_count  = 13'(sizes[k_cnt]);
    result.hit_cap       = hit;
    result.overflow      = dropped;
    result.last_cluster  = (k_cnt == KW'(KN - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= kcc_pkg::ST_LOAD;
    else     state <= state_next;
  end

  // stores
  always_ff @(posedge clk) begin
    if (accept_pt && point_count < CW'(MAX_POINTS)) begin
      point_mem[point_count[AW-1:0]] <= {point.chan_l, point.chan_a, point.chan_b};
    end
    if (state == kcc_pkg::ST_ACC) label_mem[idx[AW-1:0]] <= best;
    if (state == kcc_pkg::ST_RD) begin
      pt_q  <= point_mem[idx[AW-1:0]];
      lab_q <= label_mem[idx[AW-1:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KN; k++) seeds[k] <= '0;
      stop_thr <= 16'd10;
      iter_cap <= 8'd64;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kcc_pkg::REG_SEED_ZERO: seeds[0] <= cfg_data;
        kcc_pkg::REG_SEED_ONE:  seeds[1] <= cfg_data;
        kcc_pkg::REG_SEED_TWO:  seeds[2] <= cfg_data;
        kcc_pkg::REG_STOP_THR:  stop_thr <= cfg_data[15:0];
        kcc_pkg::REG_ITER_CAP:  iter_cap <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      dropped     <= 1'b0;
      hit         <= 1'b0;
      first_pass  <= 1'b1;
      prev_spread <= kcc_pkg::SPREAD_NONE;
      cur_spread  <= '0;
      pass_count  <= '0;
      k_cnt       <= '0;
      c_cnt       <= '0;
      step        <= '0;
      idx         <= '0;
      for (int k = 0; k < KN; k++) begin
        sizes[k] <= '0;
        for (int c = 0; c < kcc_pkg::CHANS; c++) begin
          means[k][c] <= '0;
          sums[k][c]  <= '0;
        end
      end
    end else begin
      unique case (state)
        kcc_pkg::ST_LOAD: begin
          if (accept_pt) begin
            if (point_count < CW'(MAX_POINTS)) point_count <= point_count + 1'b1;
            else                               dropped <= 1'b1;
          end
        end
        kcc_pkg::ST_SEED: begin
          for (int k = 0; k < KN; k++) begin
            means[k][0] <= {seeds[k][23:16], 8'h00};
            means[k][1] <= {seeds[k][15:8], 8'h00};
            means[k][2] <= {seeds[k][7:0], 8'h00};
          end
          pass_count  <= '0;
          prev_spread <= kcc_pkg::SPREAD_NONE;
          first_pass  <= 1'b1;
        end
        kcc_pkg::ST_SWEEP: begin
          for (int k = 0; k < KN; k++) begin
            sizes[k] <= '0;
            for (int c = 0; c < kcc_pkg::CHANS; c++) sums[k][c] <= '0;
          end
          spread <= '0;
          idx    <= '0;
          k_cnt  <= '0;
          c_cnt  <= '0;
        end
        kcc_pkg::ST_RD: begin
          step  <= '0;
          k_cnt <= '0;
          c_cnt <= '0;
        end
        kcc_pkg::ST_MUL: begin
          // square issued at one step, summed at the next
          if (step != 4'd9) begin
            prod <= diff * diff;
            pk   <= k_cnt;
            pc   <= c_cnt;
            if (c_cnt == 2'd2) begin
              c_cnt <= '0;
              k_cnt <= k_cnt + 1'b1;
            end else begin
              c_cnt <= c_cnt + 1'b1;
            end
          end else begin
            k_cnt <= '0;
            c_cnt <= '0;
          end
          if (step != 4'd0) begin
            dsq[pk] <= ((pc == 2'd0) ? '0 : dsq[pk]) + kcc_pkg::DIST_W'(prod);
          end
          step <= step + 1'b1;
        end
        kcc_pkg::ST_ACC: begin
          spread      <= spread_sat;
          sizes[best] <= sizes[best] + 1'b1;
          sums[best][0] <= sums[best][0] + SW'(pt_q[23:16]);
          sums[best][1] <= sums[best][1] + SW'(pt_q[15:8]);
          sums[best][2] <= sums[best][2] + SW'(pt_q[7:0]);
          idx <= idx + 1'b1;
          if (last_idx) cur_spread <= spread_sat;
        end
        kcc_pkg::ST_CHECK: begin
          k_cnt <= '0;
          c_cnt <= '0;
          if (!go) begin
            hit <= 1'b0;
          end else if (pass_count >= iter_cap) begin
            hit <= 1'b1;
          end else begin
            prev_spread <= cur_spread;
            pass_count  <= pass_count + 1'b1;
            first_pass  <= 1'b0;
          end
        end
        kcc_pkg::ST_UPD: begin
          if (sizes[k_cnt] == '0) begin
            if (c_cnt == 2'd2) begin
              c_cnt <= '0;
              k_cnt <= k_cnt + 1'b1;
            end else begin
              c_cnt <= c_cnt + 1'b1;
            end
          end
        end
        kcc_pkg::ST_UPD_WAIT: begin
          if (dv_done) begin
            means[k_cnt][c_cnt] <= quo[15:0];
            if (c_cnt == 2'd2) begin
              c_cnt <= '0;
              k_cnt <= k_cnt + 1'b1;
            end else begin
              c_cnt <= c_cnt + 1'b1;
            end
          end
        end
        kcc_pkg::ST_EMIT: begin
          if (accept_res) begin
            if (k_cnt == KW'(KN - 1)) begin
              k_cnt       <= '0;
              point_count <= '0;
              dropped     <= 1'b0;
            end else begin
              k_cnt <= k_cnt + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
